>>> hdl/crc_dd_pkg.sv
`default_nettype none
package crc_dd_pkg;

	localparam int TABLE_DEPTH = 8192;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	// One queued word: either a finished string CRC or a clear of the set.
	typedef struct packed {
		logic        clr;
		logic [31:0] crc;
	} cmd_t;

	// Folds one byte into a reflected CRC-32, one bit per step.
	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> hdl/crc_dd_ram.sv
`default_nettype none
module crc_dd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/crc_dd_front.sv
`default_nettype none
module crc_dd_front import crc_dd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       operation,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic       q_full,
	output logic            push,
	output cmd_t            push_cmd
);

	logic        accept;
	logic [31:0] crc_q;
	logic [31:0] crc_nxt;

	assign accept  = start && !q_full;
	assign crc_nxt = crc_fold(crc_q, data_byte);

	// A clear travels through the queue so that it stays in order with pending searches.
	always_comb begin
		push         = 1'b0;
		push_cmd.clr = operation;
		push_cmd.crc = crc_nxt ^ CRC_ONES;
		if (accept) begin
			push = operation || last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_ONES;
		end else if (accept) begin
			if (operation || last_byte) begin
				crc_q <= CRC_ONES;
			end else begin
				crc_q <= crc_nxt;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/crc_dd_queue.sv
`default_nettype none
module crc_dd_queue import crc_dd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	cmd_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + Q_CNT_W'(push && !full) - Q_CNT_W'(pop && !empty);
		end
	end

endmodule
`default_nettype wire

>>> hdl/crc_dd_back.sv
`default_nettype none
module crc_dd_back import crc_dd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_empty,
	input  cmd_t        head,
	output logic        pop,
	output logic        valid,
	output logic [31:0] string_crc,
	output logic        duplicate,
	output logic        table_full
);

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t           state_q;
	logic [31:0]      key_q;
	logic [CNT_W-1:0] addr_q;
	logic [CNT_W-1:0] count_q;
	logic             cmp_vld_q;
	logic             last_cmp_q;

	logic        issue;
	logic        hit;
	logic        done;
	logic        finish;
	logic        tbl_full;
	logic [31:0] fin_key;
	logic        we;
	logic [31:0] rd_data;

	assign pop = (state_q == ST_IDLE) && !q_empty;

	// The entry read last cycle is compared now; the walk stops at the first match.
	assign hit      = cmp_vld_q && (rd_data == key_q);
	assign done     = (state_q == ST_SEARCH) && cmp_vld_q && (hit || last_cmp_q);
	assign issue    = (state_q == ST_SEARCH) && (addr_q < count_q) && !done;
	assign finish   = done || (pop && !head.clr && (count_q == '0));
	assign fin_key  = (state_q == ST_IDLE) ? head.crc : key_q;
	assign tbl_full = (count_q == CNT_W'(TABLE_DEPTH));
	assign we       = finish && !hit && !tbl_full;

	crc_dd_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(fin_key),
		.re   (issue),
		.raddr(addr_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			key_q      <= '0;
			count_q    <= '0;
			addr_q     <= '0;
			cmp_vld_q  <= 1'b0;
			last_cmp_q <= 1'b0;
			valid      <= 1'b0;
			string_crc <= '0;
			duplicate  <= 1'b0;
			table_full <= 1'b0;
		end else begin
			valid     <= finish;
			cmp_vld_q <= issue;
			if (issue) begin
				addr_q     <= addr_q + 1'b1;
				last_cmp_q <= (addr_q == count_q - 1'b1);
			end
			if (finish) begin
				string_crc <= fin_key;
				duplicate  <= hit;
				table_full <= !hit && tbl_full;
			end
			if (we) begin
				count_q <= count_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						key_q  <= head.crc;
						addr_q <= '0;
						if (head.clr) begin
							count_q <= '0;
						end else if (count_q != '0) begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (done) begin
						state_q   <= ST_IDLE;
						cmp_vld_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/crc32_string_duplicate_detector_top.sv
// Channel   Handshake             Words
// input     start / busy          operation, data_byte, last_byte
// result    valid (one cycle)     string_crc, duplicate, table_full
//
// A byte is taken every cycle while busy is low; the CRC of a byte is folded in that cycle.
// Each string end or clear goes into a two-word queue in front of the table search.
// The search reads one stored CRC per cycle from the table RAM until it finds a match
// or reads the last entry; a clear or an end on an empty set needs no search.
// busy is high while the queue is full. The result receiver cannot stall.
// Reset empties the set at once by zeroing the entry count; no clearing pass is needed.
`default_nettype none
module crc32_string_duplicate_detector_top import crc_dd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	output logic        busy,
	input  wire logic   operation,
	input  wire logic [7:0] data_byte,
	input  wire logic   last_byte,
	output logic        valid,
	output logic [31:0] string_crc,
	output logic        duplicate,
	output logic        table_full
);

	logic push;
	cmd_t push_cmd;
	logic pop;
	cmd_t head;
	logic q_empty;
	logic q_full;

	assign busy = q_full;

	crc_dd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	crc_dd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	crc_dd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.valid     (valid),
		.string_crc(string_crc),
		.duplicate (duplicate),
		.table_full(table_full)
	);

endmodule
`default_nettype wire

>>> hdl/crc_dd_checker.sv
`default_nettype none
module crc_dd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic valid,
	input wire logic duplicate,
	input wire logic table_full
);

	// A duplicate is never also reported as a failed insert.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !(duplicate && table_full))
		else $error("duplicate and table_full both set");

	// Two results are never reported back to back; the next word must first be fetched.
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("results on two consecutive cycles");

	// The queue only fills because a word was just taken.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted word");

	// No result can appear in the cycle after reset releases.
	a_quiet_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !valid)
		else $error("result right after reset");

endmodule

bind crc32_string_duplicate_detector_top crc_dd_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.valid     (valid),
	.duplicate (duplicate),
	.table_full(table_full)
);
`default_nettype wire
